// ----- rtl/gpfb_pkg.sv -----
// Shared constants, payload types and control structs for the glyph framebuffer.
// No dependencies; imported by every module of the block.
package gpfb_pkg;

   localparam int FRAME_BYTES   = 1024;
   localparam int SCREEN_WIDTH  = 128;
   localparam int GLYPH_ROWS    = 7;
   localparam int GLYPH_COLS    = 5;
   localparam int PAGE_COUNT    = FRAME_BYTES / SCREEN_WIDTH;
   localparam int SCREEN_HEIGHT = PAGE_COUNT * 8;

   localparam int ADDR_W       = $clog2(FRAME_BYTES);
   localparam int FIELD_ADDR_W = 10;
   localparam int GLYPH_W      = 35;
   localparam int CX_W         = 7;
   localparam int CY_W         = 8;
   localparam int PAGE0_W      = CY_W - 3;
   localparam int XS_W         = CX_W + 2;
   localparam int YS_W         = CY_W + 1;
   localparam int SLOTS        = 2 * GLYPH_COLS;
   localparam int SLOT_W       = $clog2(SLOTS);

   localparam int CHAR_ADV_W = 5;
   localparam int WRAP_W     = 8;
   localparam int LINE_ADV_W = 5;
   localparam int PADDR_W    = 4;
   localparam int PDATA_W    = 32;

   localparam logic [CHAR_ADV_W-1:0] CHAR_ADV_RST   = 5'd8;
   localparam logic [WRAP_W-1:0]     WRAP_LIMIT_RST = 8'd120;
   localparam logic [LINE_ADV_W-1:0] LINE_ADV_RST   = 5'd8;

   localparam logic [1:0] REG_CHAR_ADV   = 2'd0;
   localparam logic [1:0] REG_WRAP_LIMIT = 2'd1;
   localparam logic [1:0] REG_LINE_ADV   = 2'd2;

   localparam logic FUNC_DRAW = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic                    func;
      logic [GLYPH_W-1:0]      glyph_rows;
      logic [FIELD_ADDR_W-1:0] read_addr;
   } req_type;

   typedef struct packed {
      logic [FIELD_ADDR_W-1:0] byte_addr;
      logic [7:0]              byte_value;
      logic                    wrote;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [CHAR_ADV_W-1:0] char_advance;
      logic [WRAP_W-1:0]     wrap_limit;
      logic [LINE_ADV_W-1:0] line_advance;
   } cfg_type;

   typedef struct packed {
      logic clr_step;
      logic latch;
      logic setup;
      logic rd_slot;
      logic merge;
      logic rd_byte;
      logic out_read;
      logic out_blank;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic out_free;
      logic pend_any;
   } sts_type;

endpackage

// ----- rtl/gpfb_csr.sv -----
// Configuration registers behind the APB-style port.
// Depends on gpfb_pkg.
module gpfb_csr import gpfb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type    cfg_ff;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.char_advance <= CHAR_ADV_RST;
         cfg_ff.wrap_limit   <= WRAP_LIMIT_RST;
         cfg_ff.line_advance <= LINE_ADV_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_CHAR_ADV:   cfg_ff.char_advance <= pwdata[CHAR_ADV_W-1:0];
            REG_WRAP_LIMIT: cfg_ff.wrap_limit   <= pwdata[WRAP_W-1:0];
            REG_LINE_ADV:   cfg_ff.line_advance <= pwdata[LINE_ADV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CHAR_ADV:   prdata = PDATA_W'(cfg_ff.char_advance);
         REG_WRAP_LIMIT: prdata = PDATA_W'(cfg_ff.wrap_limit);
         REG_LINE_ADV:   prdata = PDATA_W'(cfg_ff.line_advance);
         default:        prdata = '0;
      endcase
   end

endmodule

// ----- rtl/gpfb_ctrl.sv -----
// Sequencer: clearing pass, item accept, per-byte read-modify-write steps, read and blank results.
// Depends on gpfb_pkg; drives gpfb_dp through cmd_type, reads sts_type.
module gpfb_ctrl import gpfb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_func,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_SLOT  = 3'd3;
   localparam logic [2:0] ST_MERGE = 3'd4;
   localparam logic [2:0] ST_RDMEM = 3'd5;
   localparam logic [2:0] ST_RDOUT = 3'd6;
   localparam logic [2:0] ST_BLANK = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = !sts.clr_done;
            if (sts.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = (req_func == FUNC_READ) ? ST_RDMEM : ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_SLOT;
         end
         ST_SLOT: begin
            if (sts.pend_any) begin
               cmd.rd_slot = 1'b1;
               state_in    = ST_MERGE;
            end else begin
               state_in = ST_BLANK;
            end
         end
         ST_MERGE: begin
            if (sts.out_free) begin
               cmd.merge = 1'b1;
               if (sts.pend_any) cmd.rd_slot = 1'b1;
               else              state_in    = ST_IDLE;
            end
         end
         ST_RDMEM: begin
            cmd.rd_byte = 1'b1;
            state_in    = ST_RDOUT;
         end
         ST_RDOUT: begin
            if (sts.out_free) begin
               cmd.out_read = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_BLANK: begin
            if (sts.out_free) begin
               cmd.out_blank = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

// ----- rtl/gpfb_dp.sv -----
// Datapath: framebuffer memory, cursor, glyph byte masks and result register.
// Depends on gpfb_pkg; steered by gpfb_ctrl.
module gpfb_dp import gpfb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cfg_type cfg,
   input  cmd_type cmd,
   input  logic    rsp_stall,
   output sts_type sts,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   function automatic logic [SLOTS-1:0][7:0] glyph_masks(
      input logic [GLYPH_W-1:0] g,
      input logic [CX_W-1:0]    cx,
      input logic [CY_W-1:0]    cy
   );
      logic [SLOTS-1:0][7:0] m;
      logic [XS_W-1:0]       x;
      logic [YS_W-1:0]       y;
      logic [3:0]            yo;
      int                    s;
      m = '0;
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         for (int c = 0; c < GLYPH_COLS; c++) begin
            x  = XS_W'(cx) + XS_W'(c);
            y  = YS_W'(cy) + YS_W'(r);
            yo = 4'(cy[2:0]) + 4'(r);
            s  = yo[3] ? c + GLYPH_COLS : c;
            if (g[GLYPH_COLS * r + GLYPH_COLS - 1 - c] && int'(x) < SCREEN_WIDTH
                && int'(y) < SCREEN_HEIGHT)
               m[s][y[2:0]] = 1'b1;
         end
      end
      return m;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(
      input logic [PAGE0_W-1:0] pg,
      input logic [CX_W-1:0]    bx,
      input logic [SLOT_W-1:0]  s
   );
      int p;
      int c;
      p = (int'(s) >= GLYPH_COLS) ? 1 : 0;
      c = (p == 1) ? int'(s) - GLYPH_COLS : int'(s);
      return ADDR_W'((int'(pg) + p) * SCREEN_WIDTH + int'(bx) + c);
   endfunction

   logic [7:0]            frame_mem [FRAME_BYTES];

   logic [ADDR_W-1:0]     clr_cnt_ff;
   logic                  clr_done_ff;
   req_type               req_ff;
   logic [CX_W-1:0]       cx_ff;
   logic [CY_W-1:0]       cy_ff;
   logic [PAGE0_W-1:0]    page0_ff;
   logic [CX_W-1:0]       base_x_ff;
   logic [SLOTS-1:0][7:0] mask_ff;
   logic [SLOTS-1:0]      pend_ff;
   logic [SLOT_W-1:0]     cur_slot_ff;
   logic [7:0]            rd_data_ff;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   logic [SLOTS-1:0][7:0] mask_new;
   logic [SLOTS-1:0]      pend_new;
   logic [SLOT_W-1:0]     next_slot;
   logic [CX_W:0]         x_sum;
   logic                  wrap;
   logic                  mem_we;
   logic                  mem_re;
   logic [ADDR_W-1:0]     mem_wa;
   logic [ADDR_W-1:0]     mem_ra;
   logic [7:0]            mem_wd;
   logic [ADDR_W-1:0]     cur_addr;
   logic                  rd_in_range;
   logic                  out_load;

   assign mask_new = glyph_masks(req_ff.glyph_rows, cx_ff, cy_ff);

   always_comb begin
      for (int s = 0; s < SLOTS; s++) pend_new[s] = |mask_new[s];
   end

   always_comb begin
      next_slot = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (pend_ff[s]) next_slot = SLOT_W'(s);
      end
   end

   assign x_sum = (CX_W + 1)'(cx_ff) + (CX_W + 1)'(cfg.char_advance);
   assign wrap  = ((CX_W + 1)'(x_sum) >= (CX_W + 1)'(cfg.wrap_limit));

   assign cur_addr    = slot_addr(page0_ff, base_x_ff, cur_slot_ff);
   assign rd_in_range = (int'(req_ff.read_addr) < FRAME_BYTES);

   assign mem_we = cmd.clr_step || cmd.merge;
   assign mem_wa = cmd.clr_step ? clr_cnt_ff : cur_addr;
   assign mem_wd = cmd.clr_step ? 8'd0 : (rd_data_ff | mask_ff[cur_slot_ff]);
   assign mem_re = cmd.rd_slot || cmd.rd_byte;
   assign mem_ra = cmd.rd_byte ? ADDR_W'(req_ff.read_addr)
                               : slot_addr(page0_ff, base_x_ff, next_slot);

   always_ff @(posedge clock) begin
      if (mem_we) frame_mem[mem_wa] <= mem_wd;
      if (mem_re) rd_data_ff <= frame_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_done_ff <= 1'b0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         if (clr_cnt_ff == ADDR_W'(FRAME_BYTES - 1)) clr_done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) req_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff       <= '0;
         cy_ff       <= '0;
         pend_ff     <= '0;
         cur_slot_ff <= '0;
      end else if (cmd.setup) begin
         pend_ff <= pend_new;
         if (wrap) begin
            cx_ff <= '0;
            cy_ff <= cy_ff + CY_W'(cfg.line_advance);
         end else begin
            cx_ff <= x_sum[CX_W-1:0];
         end
      end else if (cmd.rd_slot) begin
         pend_ff[next_slot] <= 1'b0;
         cur_slot_ff        <= next_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         mask_ff   <= mask_new;
         page0_ff  <= cy_ff[CY_W-1:3];
         base_x_ff <= cx_ff;
      end
   end

   assign out_load = cmd.merge || cmd.out_read || cmd.out_blank;

   always_ff @(posedge clock) begin
      if (reset)          rsp_valid_ff <= 1'b0;
      else if (out_load)  rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   // pending bits already exclude the slot being merged
   always_ff @(posedge clock) begin
      priority if (cmd.merge) begin
         rsp_ff.byte_addr  <= FIELD_ADDR_W'(cur_addr);
         rsp_ff.byte_value <= mem_wd;
         rsp_ff.wrote      <= 1'b1;
         rsp_ff.last       <= ~|pend_ff;
      end else if (cmd.out_read) begin
         rsp_ff.byte_addr  <= req_ff.read_addr;
         rsp_ff.byte_value <= rd_in_range ? rd_data_ff : 8'd0;
         rsp_ff.wrote      <= 1'b0;
         rsp_ff.last       <= 1'b1;
      end else if (cmd.out_blank) begin
         rsp_ff.byte_addr  <= '0;
         rsp_ff.byte_value <= 8'd0;
         rsp_ff.wrote      <= 1'b0;
         rsp_ff.last       <= 1'b1;
      end
   end

   assign sts.clr_done = clr_done_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign sts.pend_any = |pend_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/glyph_to_page_framebuffer.sv -----
// Glyph blitter into a 128x64 page-organized framebuffer, with read-back.
// Draw: one result per touched byte (up to 10), one per cycle while rsp_stall is low.
// A blank glyph and a read each give a single result.
// Next item is taken once the previous is issued. Reset is synchronous; after it a
// clearing pass zeros the frame memory, with req_stall held high. Cursor returns
// to 0,0 and registers to 8, 120, 8.
module glyph_to_page_framebuffer import gpfb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   gpfb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gpfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gpfb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/gpfb_chk.sv -----
// Port-level assertions for the glyph framebuffer, bound to the top level.
// Depends on gpfb_pkg and glyph_to_page_framebuffer.
module gpfb_chk import gpfb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rst_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rst_clearing: assert property (@(posedge clock) reset |=> req_stall)
      else $error("item taken during memory clear");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_nowrite_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.wrote |-> rsp_data.last)
      else $error("non-write result not final");

   a_write_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.wrote |-> rsp_data.byte_value != 8'd0)
      else $error("written byte has no lit pixel");

endmodule

bind glyph_to_page_framebuffer gpfb_chk u_gpfb_chk (.*);
